// ===== hw/rtl/dsv_pkg.sv =====
// Shared constants and types of the dispatch span validator.
`default_nettype none

package dsv_pkg;

  localparam int MAX_JOBS   = 64;
  localparam int ADDR_BITS  = 48;
  localparam int LEN_BITS   = 33;
  localparam int ALIGN_BITS = 13;
  localparam int JOB_BITS   = 6;
  localparam int IDX_BITS   = 7;
  localparam int CNT_BITS   = $clog2(MAX_JOBS + 1);
  localparam int WIDE_BITS  = (ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS;
  localparam int LIM_BITS   = WIDE_BITS + 1;
  localparam int CFG_DATA_BITS = WIDE_BITS;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_REGION_START = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_POOL_BYTES   = CFG_IDX_BITS'(1);

  // Verdict codes of a result beat.
  typedef enum logic [2:0] {
    V_OK      = 3'd0,
    V_BAD_IN  = 3'd1,
    V_BAD_OUT = 3'd2,
    V_OVERLAP = 3'd3,
    V_COLLIDE = 3'd4,
    V_SKIP    = 3'd5
  } verdict_e;

  // A span as the cells see it: start address and exclusive limit.
  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [LIM_BITS-1:0]  limit;
  } span_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dispatch_span_validator.sv =====
// Dispatch span validator: checks the buffer spans of each dispatch of a batch.
//
// Usage: the pool start (index 0) and pool size (index 1) registers are written
// over the cfg channel while the block is idle; that channel is always ready.
// Each beat on the input channel is one dispatch with an input and an output span.
// One result beat comes out per dispatch: its position in the batch, a
// verdict, the batch end flag and the index of the first failed dispatch.
// Accepted output spans shift into a row of MAX_JOBS cells, newest first;
// every cell compares the new output span against its own span in parallel.
// The result is registered in the decide step, after the capture and compare
// registers. Each dispatch passes the steps capture, cell compare, and decide
// and store. The next dispatch is accepted in the cycle after the decision;
// a new dispatch is not taken before the previous one has been decided.
// Reset clears the pool registers, the span count, the job counter and the
// failure index; cell contents are left as they are and only the cells below
// the span count are used. If the receiver stalls, the decision step waits
// until the output register is free, and no new input beat is taken until
// then. A dispatch with first_job set, or the one after a last_job beat,
// starts a new batch.
`default_nettype none

module dispatch_span_validator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [dsv_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire logic [dsv_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                first_job_i,
  input  wire logic                                last_job_i,
  input  wire logic [dsv_pkg::ADDR_BITS-1:0]       in_addr_i,
  input  wire logic [dsv_pkg::LEN_BITS-1:0]        in_len_i,
  input  wire logic [dsv_pkg::ALIGN_BITS-1:0]      in_alignment_i,
  input  wire logic [dsv_pkg::ADDR_BITS-1:0]       dst_addr_i,
  input  wire logic [dsv_pkg::LEN_BITS-1:0]        out_len_i,
  input  wire logic [dsv_pkg::ALIGN_BITS-1:0]      out_alignment_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [dsv_pkg::JOB_BITS-1:0]             job_number_o,
  output logic [2:0]                               verdict_o,
  output logic                                     batch_done_o,
  output logic signed [dsv_pkg::IDX_BITS-1:0]      first_bad_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EVAL   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  localparam logic [dsv_pkg::IDX_BITS-1:0] FAIL_NONE = '1;

  // Configuration.
  logic [dsv_pkg::ADDR_BITS-1:0] region_start_q;
  logic [dsv_pkg::LEN_BITS-1:0]  pool_bytes_q;
  logic [dsv_pkg::LIM_BITS-1:0]  pool_limit_q;

  // Sequencer and batch state.
  logic [1:0]                    state_q, state_d;
  logic [dsv_pkg::CNT_BITS-1:0]  count_q, count_d;
  logic [dsv_pkg::JOB_BITS-1:0]  job_cnt_q, job_cnt_d;
  logic [dsv_pkg::IDX_BITS-1:0]  failed_q, failed_d;

  // Captured dispatch.
  logic                           first_q, last_q;
  logic [dsv_pkg::ADDR_BITS-1:0]  in_addr_q;
  logic [dsv_pkg::LEN_BITS-1:0]   in_len_q;
  logic [dsv_pkg::ALIGN_BITS-1:0] in_align_q;
  logic [dsv_pkg::LIM_BITS-1:0]   in_limit_q;
  logic [dsv_pkg::LEN_BITS-1:0]   out_len_q;
  logic [dsv_pkg::ALIGN_BITS-1:0] out_align_q;
  dsv_pkg::span_t                 query_q;

  // Check results of the compare step.
  logic in_ok, out_ok;
  logic in_ok_q, out_ok_q, io_ovl_q;

  // Result register.
  logic                          out_valid_q;
  logic [dsv_pkg::JOB_BITS-1:0]  job_number_q;
  logic [2:0]                    verdict_q, verdict;
  logic                          batch_done_q;
  logic [dsv_pkg::IDX_BITS-1:0]  first_bad_q;

  logic                          in_fire, decide_fire, shift;
  logic                          skip, collide;
  logic [dsv_pkg::CNT_BITS-1:0]  count_eff;
  logic [dsv_pkg::IDX_BITS-1:0]  failed_eff;
  logic [dsv_pkg::JOB_BITS-1:0]  num;

  dsv_pkg::span_t                chain [dsv_pkg::MAX_JOBS+1];
  logic [dsv_pkg::MAX_JOBS-1:0]  hit;
  logic [dsv_pkg::MAX_JOBS-1:0]  live;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign decide_fire = (state_q == ST_DECIDE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= '0;
      pool_bytes_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dsv_pkg::REG_REGION_START: region_start_q <= cfg_data_i[dsv_pkg::ADDR_BITS-1:0];
        dsv_pkg::REG_POOL_BYTES:   pool_bytes_q   <= cfg_data_i[dsv_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The pool limit is registered from both registers. The user must write
  // them only while idle, ahead of the next dispatch; this is not enforced.
  always_ff @(posedge clk_i) begin
    pool_limit_q <= dsv_pkg::LIM_BITS'(region_start_q) + dsv_pkg::LIM_BITS'(pool_bytes_q);
  end

  // Capture the dispatch and its span limits.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      first_q       <= first_job_i;
      last_q        <= last_job_i;
      in_addr_q     <= in_addr_i;
      in_len_q      <= in_len_i;
      in_align_q    <= in_alignment_i;
      in_limit_q    <= dsv_pkg::LIM_BITS'(in_addr_i) + dsv_pkg::LIM_BITS'(in_len_i);
      out_len_q     <= out_len_i;
      out_align_q   <= out_alignment_i;
      query_q.base  <= dst_addr_i;
      query_q.limit <= dsv_pkg::LIM_BITS'(dst_addr_i) + dsv_pkg::LIM_BITS'(out_len_i);
    end
  end

  dsv_span_chk u_in_chk (
    .addr_i         (in_addr_q),
    .len_i          (in_len_q),
    .align_i        (in_align_q),
    .limit_i        (in_limit_q),
    .region_start_i (region_start_q),
    .pool_limit_i   (pool_limit_q),
    .ok_o           (in_ok)
  );

  dsv_span_chk u_out_chk (
    .addr_i         (query_q.base),
    .len_i          (out_len_q),
    .align_i        (out_align_q),
    .limit_i        (query_q.limit),
    .region_start_i (region_start_q),
    .pool_limit_i   (pool_limit_q),
    .ok_o           (out_ok)
  );

  always_ff @(posedge clk_i) begin
    in_ok_q  <= in_ok;
    out_ok_q <= out_ok;
    io_ovl_q <= (dsv_pkg::LIM_BITS'(in_addr_q) < query_q.limit) &&
                (dsv_pkg::LIM_BITS'(query_q.base) < in_limit_q);
  end

  // Row of span cells; cell 0 takes the newest accepted span.
  assign chain[0] = query_q;

  for (genvar k = 0; k < dsv_pkg::MAX_JOBS; k++) begin : g_cell
    dsv_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .prev_i  (chain[k]),
      .query_i (query_q),
      .span_o  (chain[k+1]),
      .hit_o   (hit[k])
    );
    assign live[k] = (dsv_pkg::CNT_BITS'(k) < count_eff);
  end

  // A new batch takes the span count as zero, so no stored span is used when this dispatch is checked.
  assign count_eff  = first_q ? '0 : count_q;
  assign failed_eff = first_q ? FAIL_NONE : failed_q;
  assign num        = first_q ? '0 : job_cnt_q;
  assign skip       = (failed_eff != FAIL_NONE);
  assign collide    = |(hit & live);

  always_comb begin
    priority if (skip) begin
      verdict = dsv_pkg::V_SKIP;
    end else if (!in_ok_q) begin
      verdict = dsv_pkg::V_BAD_IN;
    end else if (!out_ok_q) begin
      verdict = dsv_pkg::V_BAD_OUT;
    end else if (io_ovl_q) begin
      verdict = dsv_pkg::V_OVERLAP;
    end else if (collide) begin
      verdict = dsv_pkg::V_COLLIDE;
    end else begin
      verdict = dsv_pkg::V_OK;
    end
  end

  assign shift = decide_fire && (verdict == dsv_pkg::V_OK) &&
                 (count_eff < dsv_pkg::CNT_BITS'(dsv_pkg::MAX_JOBS));

  always_comb begin
    failed_d  = failed_eff;
    count_d   = count_eff + dsv_pkg::CNT_BITS'(shift);
    job_cnt_d = num + dsv_pkg::JOB_BITS'(1);
    if (!skip && (verdict != dsv_pkg::V_OK)) begin
      failed_d = dsv_pkg::IDX_BITS'(num);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_EVAL;
      ST_EVAL:   state_d = ST_DECIDE;
      ST_DECIDE: if (decide_fire) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      job_cnt_q <= '0;
      failed_q  <= FAIL_NONE;
    end else begin
      state_q <= state_d;
      if (decide_fire) begin
        if (last_q) begin
          count_q   <= '0;
          job_cnt_q <= '0;
          failed_q  <= FAIL_NONE;
        end else begin
          count_q   <= count_d;
          job_cnt_q <= job_cnt_d;
          failed_q  <= failed_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (decide_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (decide_fire) begin
      job_number_q <= num;
      verdict_q    <= verdict;
      batch_done_q <= last_q;
      first_bad_q  <= failed_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign job_number_o = job_number_q;
  assign verdict_o    = verdict_q;
  assign batch_done_o = batch_done_q;
  assign first_bad_o  = first_bad_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dsv_pkg::CNT_BITS'(dsv_pkg::MAX_JOBS))
    else $error("span count beyond the number of cells");

  a_batch_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decide_fire && last_q) |=> (count_q == '0 && job_cnt_q == '0 &&
                                 failed_q == FAIL_NONE))
    else $error("batch state not cleared after the last dispatch");

  a_skip_failed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o == dsv_pkg::V_SKIP) |-> (first_bad_q != FAIL_NONE))
    else $error("skipped dispatch without a recorded failure");

  a_ok_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o == dsv_pkg::V_OK) |-> (first_bad_q == FAIL_NONE))
    else $error("accepted dispatch after a recorded failure");

  a_no_shift_skip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift |-> (!skip && in_ok_q && out_ok_q && !io_ovl_q && !collide))
    else $error("span stored for a dispatch that did not pass");

endmodule

`default_nettype wire

// ===== hw/rtl/dsv_span_chk.sv =====
// Validity check of one span: null, empty, alignment and pool bounds.
`default_nettype none

module dsv_span_chk (
  input  wire logic [dsv_pkg::ADDR_BITS-1:0]  addr_i,
  input  wire logic [dsv_pkg::LEN_BITS-1:0]   len_i,
  input  wire logic [dsv_pkg::ALIGN_BITS-1:0] align_i,
  input  wire logic [dsv_pkg::LIM_BITS-1:0]   limit_i,
  input  wire logic [dsv_pkg::ADDR_BITS-1:0]  region_start_i,
  input  wire logic [dsv_pkg::LIM_BITS-1:0]   pool_limit_i,
  output logic                                ok_o
);

  logic [dsv_pkg::ALIGN_BITS-1:0] mask;
  logic                           misaligned;

  // A zero alignment gives an all-ones mask, but it counts as misaligned for any address.
  assign mask       = align_i - dsv_pkg::ALIGN_BITS'(1);
  assign misaligned = (align_i == '0) ? 1'b1
                    : (|(addr_i[dsv_pkg::ALIGN_BITS-1:0] & mask));

  // Inside the pool exactly when base <= addr and addr + len <= base + bytes.
  assign ok_o = (addr_i != '0) && (len_i != '0) && !misaligned &&
                (addr_i >= region_start_i) && (limit_i <= pool_limit_i);

endmodule

`default_nettype wire

// ===== hw/rtl/dsv_cell.sv =====
// One storage cell of the span chain: holds an accepted output span and
// compares the current query against it.
`default_nettype none

module dsv_cell (
  input  wire logic           clk_i,
  input  wire logic           shift_i,
  input  wire dsv_pkg::span_t prev_i,
  input  wire dsv_pkg::span_t query_i,
  output dsv_pkg::span_t      span_o,
  output logic                hit_o
);

  dsv_pkg::span_t span_q;
  logic           hit_q;
  logic           hit_d;

  // Both spans are non-empty here, so two limit compares decide overlap.
  assign hit_d = (query_i.base < span_q.limit) &&
                 (dsv_pkg::LIM_BITS'(span_q.base) < query_i.limit);

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      span_q <= prev_i;
    end
    hit_q <= hit_d;
  end

  assign span_o = span_q;
  assign hit_o  = hit_q;

endmodule

`default_nettype wire
